// ===== hw/rtl/urb_pkg.sv =====
package urb_pkg;

    typedef enum logic [1:0] {
        REQ_RX_BYTE  = 2'd0,
        REQ_HOST_RD  = 2'd1,
        REQ_HOST_WR  = 2'd2,
        REQ_TX_DONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_COMMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // capture the input transfer
        logic rd_mem;    // registered read of both stores at their read pointers
        logic commit;    // apply the item, write stores, load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;  // result register still holds an untaken result
    } t_dp_status;

    localparam int unsigned RX_FILL_W = 5;
    localparam int unsigned TX_FILL_W = 6;

endpackage

// ===== hw/rtl/urb_ctrl.sv =====
module urb_ctrl
    import urb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.load_in = 1'b0;
        o_cmd.rd_mem  = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            S_READ: begin
                o_cmd.rd_mem = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = !i_status.out_busy;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/urb_dpath.sv =====
module urb_dpath
    import urb_pkg::*;
#(
    parameter int unsigned RX_DEPTH = 32,
    parameter int unsigned TX_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic [1:0]           i_req_type,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_rx_error,
    input  logic [7:0]           i_write_byte,
    input  logic                 i_tx_reg_empty,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [7:0]           o_read_byte,
    output logic                 o_read_valid,
    output logic                 o_write_accepted,
    output logic [7:0]           o_send_byte,
    output logic                 o_send_valid,
    output logic                 o_rx_overflow,
    output logic [RX_FILL_W-1:0] o_rx_fill,
    output logic [TX_FILL_W-1:0] o_tx_fill
);

    localparam int unsigned RX_AW = $clog2(RX_DEPTH);
    localparam int unsigned TX_AW = $clog2(TX_DEPTH);
    localparam int unsigned RX_CW = RX_AW;              // count never reaches depth
    localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);

    // captured item
    t_req       r_req;
    logic [7:0] r_rx_byte;
    logic       r_rx_err;
    logic [7:0] r_wr_byte;
    logic       r_tx_empty;

    // ring state
    logic [RX_AW-1:0] r_rx_wr_ptr, n_rx_wr_ptr;
    logic [RX_AW-1:0] r_rx_rd_ptr, n_rx_rd_ptr;
    logic [RX_CW-1:0] r_rx_cnt,    n_rx_cnt;
    logic             r_ovf,       n_ovf;
    logic [TX_AW-1:0] r_tx_wr_ptr, n_tx_wr_ptr;
    logic [TX_AW-1:0] r_tx_rd_ptr, n_tx_rd_ptr;
    logic [TX_CW-1:0] r_tx_cnt,    n_tx_cnt;

    logic [7:0] r_rx_mem [RX_DEPTH];
    logic [7:0] r_tx_mem [TX_DEPTH];
    logic [7:0] r_rx_q;
    logic [7:0] r_tx_q;

    logic rx_we;
    logic tx_we;

    // result register
    logic                 r_out_valid;
    logic [7:0]           r_read_byte,  n_read_byte;
    logic                 r_read_valid, n_read_valid;
    logic                 r_wr_acc,     n_wr_acc;
    logic [7:0]           r_send_byte,  n_send_byte;
    logic                 r_send_valid, n_send_valid;
    logic                 r_ovf_out;
    logic [RX_FILL_W-1:0] r_rx_fill;
    logic [TX_FILL_W-1:0] r_tx_fill;

    logic [RX_CW+RX_FILL_W-1:0] rx_fill_ext;
    logic [TX_CW+TX_FILL_W-1:0] tx_fill_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req      <= t_req'(i_req_type);
            r_rx_byte  <= i_rx_byte;
            r_rx_err   <= i_rx_error;
            r_wr_byte  <= i_write_byte;
            r_tx_empty <= i_tx_reg_empty;
        end
    end

    always_comb begin
        n_rx_wr_ptr  = r_rx_wr_ptr;
        n_rx_rd_ptr  = r_rx_rd_ptr;
        n_rx_cnt     = r_rx_cnt;
        n_ovf        = r_ovf;
        n_tx_wr_ptr  = r_tx_wr_ptr;
        n_tx_rd_ptr  = r_tx_rd_ptr;
        n_tx_cnt     = r_tx_cnt;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        n_read_byte  = 8'd0;
        n_read_valid = 1'b0;
        n_wr_acc     = 1'b0;
        n_send_byte  = 8'd0;
        n_send_valid = 1'b0;
        unique case (r_req)
            REQ_RX_BYTE: begin
                if (!r_rx_err) begin
                    rx_we       = 1'b1;
                    n_rx_wr_ptr = (r_rx_wr_ptr == RX_AW'(RX_DEPTH - 1)) ?
                                  '0 : r_rx_wr_ptr + 1'b1;
                    // filling to depth wraps the count and latches overflow
                    if (r_rx_cnt == RX_CW'(RX_DEPTH - 1)) begin
                        n_rx_cnt = '0;
                        n_ovf    = 1'b1;
                    end else begin
                        n_rx_cnt = r_rx_cnt + 1'b1;
                    end
                end
            end
            REQ_HOST_RD: begin
                if (r_rx_cnt != '0) begin
                    n_read_byte  = r_rx_q;
                    n_read_valid = 1'b1;
                    n_rx_rd_ptr  = (r_rx_rd_ptr == RX_AW'(RX_DEPTH - 1)) ?
                                   '0 : r_rx_rd_ptr + 1'b1;
                    n_rx_cnt     = r_rx_cnt - 1'b1;
                end
            end
            REQ_HOST_WR: begin
                if (r_tx_cnt != TX_CW'(TX_DEPTH)) begin
                    n_wr_acc = 1'b1;
                    if (r_tx_cnt != '0 || !r_tx_empty) begin
                        tx_we       = 1'b1;
                        n_tx_wr_ptr = (r_tx_wr_ptr == TX_AW'(TX_DEPTH - 1)) ?
                                      '0 : r_tx_wr_ptr + 1'b1;
                        n_tx_cnt    = r_tx_cnt + 1'b1;
                    end else begin
                        n_send_byte  = r_wr_byte;
                        n_send_valid = 1'b1;
                    end
                end
            end
            REQ_TX_DONE: begin
                if (r_tx_cnt != '0) begin
                    n_send_byte  = r_tx_q;
                    n_send_valid = 1'b1;
                    n_tx_rd_ptr  = (r_tx_rd_ptr == TX_AW'(TX_DEPTH - 1)) ?
                                   '0 : r_tx_rd_ptr + 1'b1;
                    n_tx_cnt     = r_tx_cnt - 1'b1;
                end
            end
            default: begin
                n_send_valid = 1'b0;
            end
        endcase
    end

    assign rx_fill_ext = {{RX_FILL_W{1'b0}}, n_rx_cnt};
    assign tx_fill_ext = {{TX_FILL_W{1'b0}}, n_tx_cnt};

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && rx_we) begin
            r_rx_mem[r_rx_wr_ptr] <= r_rx_byte;
        end
        if (i_cmd.rd_mem) begin
            r_rx_q <= r_rx_mem[r_rx_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && tx_we) begin
            r_tx_mem[r_tx_wr_ptr] <= r_wr_byte;
        end
        if (i_cmd.rd_mem) begin
            r_tx_q <= r_tx_mem[r_tx_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr_ptr <= '0;
            r_rx_rd_ptr <= '0;
            r_rx_cnt    <= '0;
            r_ovf       <= 1'b0;
            r_tx_wr_ptr <= '0;
            r_tx_rd_ptr <= '0;
            r_tx_cnt    <= '0;
            r_out_valid <= 1'b0;
            r_ovf_out   <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_rx_wr_ptr <= n_rx_wr_ptr;
                r_rx_rd_ptr <= n_rx_rd_ptr;
                r_rx_cnt    <= n_rx_cnt;
                r_ovf       <= n_ovf;
                r_tx_wr_ptr <= n_tx_wr_ptr;
                r_tx_rd_ptr <= n_tx_rd_ptr;
                r_tx_cnt    <= n_tx_cnt;
                r_out_valid <= 1'b1;
                r_ovf_out   <= n_ovf;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_read_byte  <= n_read_byte;
            r_read_valid <= n_read_valid;
            r_wr_acc     <= n_wr_acc;
            r_send_byte  <= n_send_byte;
            r_send_valid <= n_send_valid;
            r_rx_fill    <= rx_fill_ext[RX_FILL_W-1:0];
            r_tx_fill    <= tx_fill_ext[TX_FILL_W-1:0];
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_read_byte      = r_read_byte;
    assign o_read_valid     = r_read_valid;
    assign o_write_accepted = r_wr_acc;
    assign o_send_byte      = r_send_byte;
    assign o_send_valid     = r_send_valid;
    assign o_rx_overflow    = r_ovf_out;
    assign o_rx_fill        = r_rx_fill;
    assign o_tx_fill        = r_tx_fill;

endmodule

// ===== hw/rtl/uart_rx_tx_ring_buffers_unit.sv =====
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    req_type, rx_byte, rx_error,
//                                                write_byte, tx_reg_empty
// out      output     o_out_valid / i_out_stall  read_byte, read_valid,
//                                                write_accepted, send_byte,
//                                                send_valid, rx_overflow,
//                                                rx_fill, tx_fill
//
// Each item goes through transfer in, registered read of both stores at
// their read pointers, then commit of pointers, counts and the result.
// The registered store read port is why the read step exists; one item is in flight at a time.
// The result register lets the next item transfer in while a result waits;
// commit of that next item holds as long as the previous result is stalled.
// Reset (synchronous, active low) clears pointers, counts, the overflow flag
// and output valid; store contents are undefined until written.
module uart_rx_tx_ring_buffers_unit
    import urb_pkg::*;
#(
    parameter int unsigned RX_DEPTH = 32,
    parameter int unsigned TX_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_rx_error,
    input  logic [7:0]           i_write_byte,
    input  logic                 i_tx_reg_empty,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_read_byte,
    output logic                 o_read_valid,
    output logic                 o_write_accepted,
    output logic [7:0]           o_send_byte,
    output logic                 o_send_valid,
    output logic                 o_rx_overflow,
    output logic [RX_FILL_W-1:0] o_rx_fill,
    output logic [TX_FILL_W-1:0] o_tx_fill
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer: idle -> read -> commit
    urb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // rings, stores and the result register
    urb_dpath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_req_type       (i_req_type),
        .i_rx_byte        (i_rx_byte),
        .i_rx_error       (i_rx_error),
        .i_write_byte     (i_write_byte),
        .i_tx_reg_empty   (i_tx_reg_empty),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_read_byte      (o_read_byte),
        .o_read_valid     (o_read_valid),
        .o_write_accepted (o_write_accepted),
        .o_send_byte      (o_send_byte),
        .o_send_valid     (o_send_valid),
        .o_rx_overflow    (o_rx_overflow),
        .o_rx_fill        (o_rx_fill),
        .o_tx_fill        (o_tx_fill)
    );

endmodule

// ===== hw/rtl/urb_chk.sv =====
module urb_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_req_type,
    input logic [7:0] i_rx_byte,
    input logic       i_rx_error,
    input logic [7:0] i_write_byte,
    input logic       i_tx_reg_empty,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_read_byte,
    input logic       o_read_valid,
    input logic       o_write_accepted,
    input logic [7:0] o_send_byte,
    input logic       o_send_valid,
    input logic       o_rx_overflow,
    input logic [4:0] o_rx_fill,
    input logic [5:0] o_tx_fill
);

    // stalled input transfer holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_req_type)
            && $stable(i_rx_byte) && $stable(i_rx_error) && $stable(i_write_byte)
            && $stable(i_tx_reg_empty))
        else $error("stalled input changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_byte)
            && $stable(o_send_byte) && $stable(o_rx_fill) && $stable(o_tx_fill))
        else $error("stalled result changed");

    // after its transfer, an item keeps the input stalled through the read and commit states
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall)
        else $error("input taken while an item is in flight");

    // overflow is sticky
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_overflow |=> o_rx_overflow)
        else $error("overflow flag cleared");

    // a read result never comes with a transmit result
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_read_valid && (o_send_valid || o_write_accepted)))
        else $error("read result mixed with transmit result");

endmodule

bind uart_rx_tx_ring_buffers_unit urb_chk u_urb_chk (.*);
